// File: design/fdu_pkg.sv
// Package for the feature direction unit: widths, payload and pipeline types,
// and the sign/saturation helpers. No dependencies.
package fdu_pkg;

  localparam int COMP_W = 16;
  localparam int PW     = 2 * COMP_W;
  localparam int CW     = PW + 1;
  localparam int EXT_W  = 64;
  localparam int NGRP   = EXT_W / 8;
  localparam int POS_W  = $clog2(EXT_W);
  localparam int Q_W    = 31;
  localparam int Q_TOP  = Q_W - 1;
  localparam int SQ_W   = 2 * Q_W;
  localparam int ROOT_W = 32;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int SR_W   = ROOT_W + 2;
  localparam int DR_W   = ROOT_W + 1;
  localparam int NLANE  = 3;

  localparam logic [COMP_W-1:0] CMP_MAX  = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] CMP_MIN  = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [COMP_W-1:0] CMP_HALF = CMP_MIN;

  localparam logic MODE_WALL     = 1'b0;
  localparam logic MODE_FILAMENT = 1'b1;

  typedef struct packed {
    logic signed [COMP_W-1:0] a_x;
    logic signed [COMP_W-1:0] a_y;
    logic signed [COMP_W-1:0] a_z;
    logic signed [COMP_W-1:0] b_x;
    logic signed [COMP_W-1:0] b_y;
    logic signed [COMP_W-1:0] b_z;
  } fdu_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
    logic                     degenerate;
  } fdu_out_t;

  typedef struct packed {
    logic                        valid;
    logic                        mode;
    logic                        deg;
    logic [NLANE-1:0]            sgn;
    logic [NLANE-1:0][COMP_W-1:0] wall;
  } fdu_ctl_t;

  typedef struct packed {
    fdu_ctl_t                  ctl;
    logic [NLANE-1:0][Q_W-1:0] q;
  } fdu_sq_side_t;

  function automatic logic [COMP_W-1:0] neg_sat(input logic [COMP_W-1:0] x);
    logic [COMP_W-1:0] r;
    if (x == CMP_MIN) r = CMP_MAX;
    else r = ~x + 1'b1;
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] sign_fmt(input logic [COMP_W-1:0] mag,
                                                  input logic neg);
    logic [COMP_W-1:0] r;
    if (neg) r = ~mag + 1'b1;
    else if (mag == CMP_HALF) r = CMP_MAX;
    else r = mag;
    return r;
  endfunction

endpackage

// File: design/feature_direction_unit.sv
// Feature direction unit top level: front pipeline, square-root and divider
// cell chains, output stage. Depends on fdu_pkg, fdu_sqrt_cell, fdu_div_cell.
//
// Usage:
//   Input: drive in_data and raise start for one cycle per grid cell. busy
//   stays low, so a transaction is taken on every cycle that start is high.
//   Output: each transaction gives one result on out_data, marked by
//   out_valid for exactly one cycle, in order.
//   Throughput is one transaction per cycle; the latency is set by the
//   32-cell square-root chain and the 16-cell divider chain plus ten
//   pipeline registers around them.
//   Config: cfg_data (feature_mode) is written when cfg_valid is high;
//   cfg_ready is always high. Write it only with the pipeline empty.
//   The mode is sampled per transaction on entry.
//   Reset: synchronous rst_n clears all valid bits and sets filament mode.
//   The receiver cannot stall: results must be taken when out_valid is high.
module feature_direction_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fdu_pkg::fdu_in_t  in_data,
  output logic              out_valid,
  output fdu_pkg::fdu_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import fdu_pkg::*;

  logic mode_r;

  fdu_ctl_t ctl_nxt;
  fdu_ctl_t ctl2_nxt, ctl4_nxt;
  fdu_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r, ctl8_r;

  logic signed [PW-1:0] p1_r [6];
  logic signed [CW-1:0] c2   [NLANE];
  logic signed [CW-1:0] cf2  [NLANE];
  logic signed [CW-1:0] ab2  [NLANE];
  logic                 flip2;

  logic [NLANE-1:0][PW-1:0] mag2_r, mag3_r, mag4_r, mag5_r;
  logic [PW-1:0]            m3_nxt;
  logic [PW-1:0]            m3_r;
  logic [EXT_W-1:0]         m3_ext;
  logic [NGRP-1:0]          nz4_nxt, nz4_r;
  logic [NGRP-1:0][2:0]     loc4_nxt, loc4_r;
  logic [POS_W-1:0]         p5_nxt, p5_r;
  logic [NLANE-1:0][Q_W-1:0] q6_nxt, q6_r, q7_r, q8_r;
  logic [EXT_W-1:0]         ext6;
  logic [NLANE-1:0][SQ_W-1:0] sq7_r;
  logic [SUM_W-1:0]         sum8_r;

  // square-root chain
  logic [SUM_W-1:0]  s_w    [ROOT_W+1];
  logic [SR_W-1:0]   srem_w [ROOT_W+1];
  logic [ROOT_W-1:0] root_w [ROOT_W+1];
  fdu_sq_side_t      sside_w[ROOT_W+1];

  // divider chain
  logic [NLANE-1:0][DR_W-1:0]   drem_w [COMP_W+1];
  logic [NLANE-1:0][COMP_W-1:0] quot_w [COMP_W+1];
  logic [COMP_W-1:0]            low_w  [COMP_W+1];
  logic [DR_W-1:0]              d_w    [COMP_W+1];
  fdu_ctl_t                     dctl_w [COMP_W+1];

  logic [NLANE-1:0][DR_W-1:0] drem9_nxt;
  logic [ROOT_W-1:0]          r9;

  fdu_ctl_t                     fctl;
  logic [NLANE-1:0][COMP_W-1:0] dir_nxt;
  logic                         out_valid_r;
  fdu_out_t                     out_data_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FILAMENT;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // stage 1: products, wall result
  always_comb begin
    ctl_nxt       = '0;
    ctl_nxt.valid = start;
    ctl_nxt.mode  = mode_r;
    if (in_data.a_x[COMP_W-1]) begin
      ctl_nxt.wall[0] = neg_sat(in_data.a_x);
      ctl_nxt.wall[1] = neg_sat(in_data.a_y);
      ctl_nxt.wall[2] = neg_sat(in_data.a_z);
    end else begin
      ctl_nxt.wall[0] = in_data.a_x;
      ctl_nxt.wall[1] = in_data.a_y;
      ctl_nxt.wall[2] = in_data.a_z;
    end
  end

  always_ff @(posedge clk) begin
    p1_r[0] <= in_data.a_z * in_data.b_y;
    p1_r[1] <= in_data.a_y * in_data.b_z;
    p1_r[2] <= in_data.a_x * in_data.b_z;
    p1_r[3] <= in_data.a_z * in_data.b_x;
    p1_r[4] <= in_data.a_y * in_data.b_x;
    p1_r[5] <= in_data.a_x * in_data.b_y;
  end

  // stage 2: differences, sign fix, magnitudes
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      c2[i] = CW'(p1_r[2*i]) - CW'(p1_r[2*i+1]);
    end
    flip2 = c2[0][CW-1];
    for (int i = 0; i < NLANE; i++) begin
      cf2[i] = flip2 ? -c2[i] : c2[i];
      ab2[i] = cf2[i][CW-1] ? -cf2[i] : cf2[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      mag2_r[i] <= ab2[i][PW-1:0];
    end
  end

  // stage 3: maximum magnitude
  always_comb begin
    m3_nxt = mag2_r[0];
    if (mag2_r[1] > m3_nxt) m3_nxt = mag2_r[1];
    if (mag2_r[2] > m3_nxt) m3_nxt = mag2_r[2];
  end

  always_ff @(posedge clk) begin
    mag3_r <= mag2_r;
    m3_r   <= m3_nxt;
  end

  // stage 4: leading one per byte
  always_comb begin
    m3_ext   = EXT_W'(m3_r);
    loc4_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      nz4_nxt[g] = |m3_ext[8*g +: 8];
      for (int b = 0; b < 8; b++) begin
        if (m3_ext[8*g+b]) loc4_nxt[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    mag4_r <= mag3_r;
    nz4_r  <= nz4_nxt;
    loc4_r <= loc4_nxt;
  end

  // stage 5: leading one position
  always_comb begin
    p5_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (nz4_r[g]) p5_nxt = {3'(g), loc4_r[g]};
    end
  end

  always_ff @(posedge clk) begin
    mag5_r <= mag4_r;
    p5_r   <= p5_nxt;
  end

  // stage 6: normalize so the largest magnitude lands in [2^30, 2^31)
  always_comb begin
    ext6 = '0;
    for (int i = 0; i < NLANE; i++) begin
      ext6 = EXT_W'(mag5_r[i]);
      if (p5_r >= POS_W'(Q_TOP)) q6_nxt[i] = Q_W'(ext6 >> (p5_r - POS_W'(Q_TOP)));
      else q6_nxt[i] = Q_W'(ext6 << (POS_W'(Q_TOP) - p5_r));
    end
  end

  always_ff @(posedge clk) begin
    q6_r <= q6_nxt;
  end

  // stage 7: squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      sq7_r[i] <= SQ_W'(q6_r[i]) * SQ_W'(q6_r[i]);
    end
    q7_r <= q6_r;
  end

  // stage 8: sum of squares
  always_ff @(posedge clk) begin
    sum8_r <= SUM_W'(sq7_r[0]) + SUM_W'(sq7_r[1]) + SUM_W'(sq7_r[2]);
    q8_r   <= q7_r;
  end

  // control pipeline for the front stages
  always_comb begin
    ctl2_nxt = ctl1_r;
    for (int i = 0; i < NLANE; i++) begin
      ctl2_nxt.sgn[i] = cf2[i][CW-1];
    end
    ctl4_nxt     = ctl3_r;
    ctl4_nxt.deg = (ctl3_r.mode == MODE_FILAMENT) && (m3_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
      ctl8_r <= '0;
    end else begin
      ctl1_r <= ctl_nxt;
      ctl2_r <= ctl2_nxt;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl4_nxt;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
      ctl8_r <= ctl7_r;
    end
  end

  assign s_w[0]         = sum8_r;
  assign srem_w[0]      = '0;
  assign root_w[0]      = '0;
  assign sside_w[0].ctl = ctl8_r;
  assign sside_w[0].q   = q8_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    fdu_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .s_in     (s_w[k]),
      .rem_in   (srem_w[k]),
      .root_in  (root_w[k]),
      .side_in  (sside_w[k]),
      .s_out    (s_w[k+1]),
      .rem_out  (srem_w[k+1]),
      .root_out (root_w[k+1]),
      .side_out (sside_w[k+1])
    );
  end

  // stage 9: divider setup, num = q * 2^COMP_W + r over 2r
  always_comb begin
    r9 = root_w[ROOT_W];
    for (int i = 0; i < NLANE; i++) begin
      drem9_nxt[i] = DR_W'(sside_w[ROOT_W].q[i]) + DR_W'(r9 >> COMP_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dctl_w[0] <= '0;
    end else begin
      dctl_w[0] <= sside_w[ROOT_W].ctl;
    end
  end

  always_ff @(posedge clk) begin
    drem_w[0] <= drem9_nxt;
    quot_w[0] <= '0;
    low_w[0]  <= r9[COMP_W-1:0];
    d_w[0]    <= {r9, 1'b0};
  end

  for (genvar k = 0; k < COMP_W; k++) begin : g_div
    fdu_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rem_in   (drem_w[k]),
      .quot_in  (quot_w[k]),
      .low_in   (low_w[k]),
      .d_in     (d_w[k]),
      .ctl_in   (dctl_w[k]),
      .rem_out  (drem_w[k+1]),
      .quot_out (quot_w[k+1]),
      .low_out  (low_w[k+1]),
      .d_out    (d_w[k+1]),
      .ctl_out  (dctl_w[k+1])
    );
  end

  // stage 10: sign, saturation, mode select
  always_comb begin
    fctl = dctl_w[COMP_W];
    for (int i = 0; i < NLANE; i++) begin
      if (fctl.mode == MODE_WALL) dir_nxt[i] = fctl.wall[i];
      else if (fctl.deg) dir_nxt[i] = '0;
      else dir_nxt[i] = sign_fmt(quot_w[COMP_W][i], fctl.sgn[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.dir_x      <= dir_nxt[0];
    out_data_r.dir_y      <= dir_nxt[1];
    out_data_r.dir_z      <= dir_nxt[2];
    out_data_r.degenerate <= fctl.deg;
  end

endmodule

// File: design/fdu_sqrt_cell.sv
// One bit of the pipelined integer square root; carries the sideband along.
// Depends on fdu_pkg.
module fdu_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fdu_pkg::SUM_W-1:0]   s_in,
  input  logic [fdu_pkg::SR_W-1:0]    rem_in,
  input  logic [fdu_pkg::ROOT_W-1:0]  root_in,
  input  fdu_pkg::fdu_sq_side_t       side_in,
  output logic [fdu_pkg::SUM_W-1:0]   s_out,
  output logic [fdu_pkg::SR_W-1:0]    rem_out,
  output logic [fdu_pkg::ROOT_W-1:0]  root_out,
  output fdu_pkg::fdu_sq_side_t       side_out
);
  import fdu_pkg::*;

  logic [SR_W+1:0] sh;
  logic [SR_W+1:0] trial;
  logic [SR_W+1:0] diff;
  logic            ge;

  always_comb begin
    sh    = {rem_in, s_in[SUM_W-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    diff  = sh - trial;
    ge    = (sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_out.ctl.valid <= 1'b0;
    end else begin
      side_out.ctl.valid <= side_in.ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s_out                <= s_in << 2;
    rem_out              <= ge ? diff[SR_W-1:0] : sh[SR_W-1:0];
    root_out             <= {root_in[ROOT_W-2:0], ge};
    side_out.q           <= side_in.q;
    side_out.ctl.mode    <= side_in.ctl.mode;
    side_out.ctl.deg     <= side_in.ctl.deg;
    side_out.ctl.sgn     <= side_in.ctl.sgn;
    side_out.ctl.wall    <= side_in.ctl.wall;
  end

endmodule

// File: design/fdu_div_cell.sv
// One quotient bit of the three-lane restoring divider; carries control along.
// Depends on fdu_pkg.
module fdu_div_cell (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [fdu_pkg::NLANE-1:0][fdu_pkg::DR_W-1:0]   rem_in,
  input  logic [fdu_pkg::NLANE-1:0][fdu_pkg::COMP_W-1:0] quot_in,
  input  logic [fdu_pkg::COMP_W-1:0]                   low_in,
  input  logic [fdu_pkg::DR_W-1:0]                     d_in,
  input  fdu_pkg::fdu_ctl_t                            ctl_in,
  output logic [fdu_pkg::NLANE-1:0][fdu_pkg::DR_W-1:0]   rem_out,
  output logic [fdu_pkg::NLANE-1:0][fdu_pkg::COMP_W-1:0] quot_out,
  output logic [fdu_pkg::COMP_W-1:0]                   low_out,
  output logic [fdu_pkg::DR_W-1:0]                     d_out,
  output fdu_pkg::fdu_ctl_t                            ctl_out
);
  import fdu_pkg::*;

  logic [NLANE-1:0][DR_W:0]   sh;
  logic [NLANE-1:0][DR_W:0]   diff;
  logic [NLANE-1:0]           ge;
  logic [NLANE-1:0][DR_W-1:0] rem_nxt;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      sh[i]      = {rem_in[i], low_in[COMP_W-1]};
      diff[i]    = sh[i] - {1'b0, d_in};
      ge[i]      = (sh[i] >= {1'b0, d_in});
      rem_nxt[i] = ge[i] ? diff[i][DR_W-1:0] : sh[i][DR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      rem_out[i]  <= rem_nxt[i];
      quot_out[i] <= {quot_in[i][COMP_W-2:0], ge[i]};
    end
    low_out      <= low_in << 1;
    d_out        <= d_in;
    ctl_out.mode <= ctl_in.mode;
    ctl_out.deg  <= ctl_in.deg;
    ctl_out.sgn  <= ctl_in.sgn;
    ctl_out.wall <= ctl_in.wall;
  end

endmodule

// File: verif/fdu_checker.sv
// Result checker for the feature direction unit: tracks feature_mode, predicts
// each transaction's direction and compares the out channel. Depends on fdu_pkg.
`timescale 1ns / 100ps
module fdu_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  fdu_pkg::fdu_in_t  in_data,
  input  logic              out_valid,
  input  fdu_pkg::fdu_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  output int                fail_count,
  output int                dirs_pending,
  output int                dirs_checked,
  output int                degen_seen
);
  import fdu_pkg::*;

  logic     mode_q;
  fdu_out_t dir_q[$];

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [COMP_W-1:0] pack_sat(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      return COMP_W'(~mag + 64'd1);
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return COMP_W'(mag);
  endfunction

  function automatic fdu_out_t predict_direction(input fdu_in_t v, input logic mode);
    fdu_out_t o;
    longint   c[3];
    longint   w[3];
    logic [63:0] mg[3];
    logic [63:0] m, s, r, q;
    logic ng[3];
    o = '0;
    if (mode == MODE_WALL) begin
      w[0] = longint'(v.a_x);
      w[1] = longint'(v.a_y);
      w[2] = longint'(v.a_z);
      if (w[0] < 0) for (int i = 0; i < 3; i++) w[i] = -w[i];
      o.dir_x = pack_sat(w[0] < 0, (w[0] < 0) ? -w[0] : w[0]);
      o.dir_y = pack_sat(w[1] < 0, (w[1] < 0) ? -w[1] : w[1]);
      o.dir_z = pack_sat(w[2] < 0, (w[2] < 0) ? -w[2] : w[2]);
      return o;
    end
    c[0] = longint'(v.a_z) * longint'(v.b_y) - longint'(v.a_y) * longint'(v.b_z);
    c[1] = longint'(v.a_x) * longint'(v.b_z) - longint'(v.a_z) * longint'(v.b_x);
    c[2] = longint'(v.a_y) * longint'(v.b_x) - longint'(v.a_x) * longint'(v.b_y);
    if (c[0] < 0) for (int i = 0; i < 3; i++) c[i] = -c[i];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = c[i] < 0;
      mg[i] = ng[i] ? -c[i] : c[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
    end
    s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    r = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << COMP_W) + r) / (2 * r);
      mg[i] = q;
      ng[i] = ng[i] && q != 0;
    end
    o.dir_x = pack_sat(ng[0], mg[0]);
    o.dir_y = pack_sat(ng[1], mg[1]);
    o.dir_z = pack_sat(ng[2], mg[2]);
    return o;
  endfunction

  assign dirs_pending = dir_q.size();

  always @(posedge clk) begin
    fdu_out_t e;
    if (!rst_n) begin
      mode_q <= MODE_FILAMENT;
      dir_q.delete();
      fail_count <= 0;
      dirs_checked <= 0;
      degen_seen <= 0;
    end else begin
      if (start && !busy) dir_q.push_back(predict_direction(in_data, mode_q));
      if (cfg_valid && cfg_ready) mode_q <= cfg_data;
      if (out_valid) begin
        if (dir_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = dir_q.pop_front();
          dirs_checked <= dirs_checked + 1;
          if (out_data.degenerate) degen_seen <= degen_seen + 1;
          if (out_data != e) begin
            fail_count <= fail_count + 1;
            if (out_data.dir_x != e.dir_x)
              $error("dir_x exp %0d got %0d", e.dir_x, out_data.dir_x);
            if (out_data.dir_y != e.dir_y)
              $error("dir_y exp %0d got %0d", e.dir_y, out_data.dir_y);
            if (out_data.dir_z != e.dir_z)
              $error("dir_z exp %0d got %0d", e.dir_z, out_data.dir_z);
            if (out_data.degenerate != e.degenerate)
              $error("degenerate exp %0b got %0b", e.degenerate, out_data.degenerate);
          end
        end
      end
    end
  end
endmodule

// File: verif/tb.sv
// Testbench top for feature_direction_unit: clock, reset, directed and random
// transactions in both modes, verdict. Depends on fdu_pkg, fdu_checker and feature_direction_unit.
`timescale 1ns / 100ps
module tb;
  import fdu_pkg::*;

  logic     clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready, cfg_data;
  fdu_in_t  in_data;
  fdu_out_t out_data;
  int       fail_count, dirs_pending, dirs_checked, degen_seen;
  int       sent;

  feature_direction_unit u_dut (.*);

  fdu_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return COMP_W'($urandom_range(0, 5) == 0 ? 16'h8000 : 16'h7fff);
      1: return COMP_W'($urandom_range(0, 2) - 1);
      2: return COMP_W'($urandom_range(0, 1) ? 16'h8001 : 16'h0000);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic fdu_in_t rand_cell();
    fdu_in_t v;
    v = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    if ($urandom_range(0, 3) > 0) v = fdu_in_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      0: {v.b_x, v.b_y, v.b_z} = {v.a_x, v.a_y, v.a_z};
      1: {v.b_x, v.b_y, v.b_z} = {-v.a_x, -v.a_y, -v.a_z};
      2: {v.a_x, v.a_y, v.a_z} = '0;
      3: {v.a_x, v.b_x} = {16'sd0, 16'sd0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_cell(input fdu_in_t v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= v;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic set_mode(input logic m);
    start <= 1'b0;
    @(posedge clk);
    while (dirs_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed();
    send_cell('0);
    send_cell({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000});
    send_cell({16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000});
    send_cell({16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000});
    send_cell({16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000});
    send_cell({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001});
    send_cell({16'sh8000, 16'sh1234, 16'sh8000, 16'sh8000, 16'sh1234, 16'sh8000});
    send_cell({16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001});
    send_cell({16'shffff, 16'sh0001, 16'shffff, 16'sh0001, 16'shffff, 16'sh0000});
    send_cell({16'sh0001, 16'sh0002, 16'sh0003, 16'shfffc, 16'sh0005, 16'shfffa});
    send_cell({16'sh0000, 16'sh8000, 16'sh7fff, 16'sh5555, 16'shaaaa, 16'sh0000});
    send_cell({16'shc000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000});
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    cfg_valid = 0;
    cfg_data = 0;
    in_data = '0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    repeat (400) send_cell(rand_cell());
    set_mode(MODE_WALL);
    send_directed();
    repeat (400) send_cell(rand_cell());
    set_mode(MODE_FILAMENT);
    repeat (280) send_cell(rand_cell());
    set_mode(MODE_WALL);
    repeat (250) send_cell(rand_cell());
    start <= 1'b0;
    @(posedge clk);
    while (dirs_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d cells across wall and filament phases; %0d results checked,",
             sent, dirs_checked);
    $display("%0d of them degenerate.", degen_seen);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: sim.f
design/fdu_pkg.sv
design/fdu_sqrt_cell.sv
design/fdu_div_cell.sv
design/feature_direction_unit.sv
verif/fdu_checker.sv
verif/tb.sv
